/* rtl/orpc_pkg.sv */
// shared constants, types and lookup tables for the oriented rectangle coverage block
// no dependencies; used by rtl/oriented_rect_pixel_coverage_top.sv

package orpc_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int Q_W    = 16;
  localparam int Q_FRAC = 12;

  localparam int COL_CODES = 1 << COL_W;
  localparam int ROW_CODES = 1 << ROW_W;

  // configuration register indexes
  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_AXIS_U_X = 3'd2;
  localparam logic [2:0] REG_AXIS_U_Y = 3'd3;
  localparam logic [2:0] REG_AXIS_V_X = 3'd4;
  localparam logic [2:0] REG_AXIS_V_Y = 3'd5;

  localparam logic signed [Q_W-1:0] Q_MAX = 16'sh7fff;
  localparam logic signed [Q_W-1:0] Q_MIN = -16'sh8000;

  typedef logic signed [Q_W-1:0] q_t;
  typedef q_t px_tab_t [COL_CODES];
  typedef q_t py_tab_t [ROW_CODES];

  // clamp a wide signed value into Q3.12
  function automatic q_t sat16(input logic signed [33:0] v);
    q_t r;
    if (v > 34'sd32767) begin
      r = Q_MAX;
    end else if (v < -34'sd32768) begin
      r = Q_MIN;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  function automatic int sat_int(input int v);
    int r;
    if (v > 32767) begin
      r = 32767;
    end else if (v < -32768) begin
      r = -32768;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // floor division by the screen height, rounding towards minus infinity
  function automatic int floor_div_h(input int n);
    int q;
    q = n / SCREEN_HEIGHT;
    if ((n % SCREEN_HEIGHT) != 0 && n < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  // normalised x for every column code, scaled so that the screen width spans -1 to 1
  function automatic px_tab_t build_px_tab();
    px_tab_t t;
    for (int c = 0; c < COL_CODES; c++) begin
      t[c] = 16'(sat_int(floor_div_h((2 * c - SCREEN_WIDTH) * 2048)));
    end
    return t;
  endfunction

  // normalised y for every row code
  function automatic py_tab_t build_py_tab();
    py_tab_t t;
    for (int r = 0; r < ROW_CODES; r++) begin
      t[r] = 16'(sat_int(floor_div_h((2 * r - SCREEN_HEIGHT) * 4096)));
    end
    return t;
  endfunction

  localparam px_tab_t PX_TAB = build_px_tab();
  localparam py_tab_t PY_TAB = build_py_tab();

endpackage

/* rtl/oriented_rect_pixel_coverage_top.sv */
// oriented rectangle pixel coverage: five stage pipeline with stream ports and a config port
// depends on rtl/orpc_pkg.sv for constants, lookup tables and saturation

// Tests one screen pixel per word against a rotated rectangle given by a centre and two
// half-axis vectors in signed Q3.12. A new pixel can be taken every clock unless
// back-pressure has filled the stages; the coverage flag passes through them in order
// (table lookup, centre subtract, multiply, dot product sum, compare), and each stage holds
// its word under back-pressure.
// The squared axis lengths are rebuilt from the axis registers through two registers of
// their own (the squares, then the saturated sums), so they lag a register write.

module oriented_rect_pixel_coverage_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [6:0] pixel_column, [12:7] pixel_row, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] covered, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  orpc_pkg::q_t center_x, center_y, axis_u_x, axis_u_y, axis_v_x, axis_v_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= 16'sd0;
      center_y <= 16'sd0;
      axis_u_x <= 16'sd2048;
      axis_u_y <= 16'sd0;
      axis_v_x <= 16'sd0;
      axis_v_y <= -16'sd2048;
    end else if (cfg_valid) begin
      case (cfg_index)
        orpc_pkg::REG_CENTER_X: center_x <= cfg_data;
        orpc_pkg::REG_CENTER_Y: center_y <= cfg_data;
        orpc_pkg::REG_AXIS_U_X: axis_u_x <= cfg_data;
        orpc_pkg::REG_AXIS_U_Y: axis_u_y <= cfg_data;
        orpc_pkg::REG_AXIS_V_X: axis_v_x <= cfg_data;
        orpc_pkg::REG_AXIS_V_Y: axis_v_y <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // squared axis lengths
  logic [30:0] sq_ux, sq_uy, sq_vx, sq_vy;
  logic [14:0] len_u, len_v;
  logic signed [31:0] sq_ux_full, sq_uy_full, sq_vx_full, sq_vy_full;
  logic [31:0] lsum_u, lsum_v;

  assign sq_ux_full = axis_u_x * axis_u_x;
  assign sq_uy_full = axis_u_y * axis_u_y;
  assign sq_vx_full = axis_v_x * axis_v_x;
  assign sq_vy_full = axis_v_y * axis_v_y;
  assign lsum_u = {1'b0, sq_ux} + {1'b0, sq_uy};
  assign lsum_v = {1'b0, sq_vx} + {1'b0, sq_vy};

  always_ff @(posedge clk) begin
    sq_ux <= sq_ux_full[30:0];
    sq_uy <= sq_uy_full[30:0];
    sq_vx <= sq_vx_full[30:0];
    sq_vy <= sq_vy_full[30:0];
    len_u <= (|lsum_u[31:27]) ? 15'h7fff : lsum_u[26:12];
    len_v <= (|lsum_v[31:27]) ? 15'h7fff : lsum_v[26:12];
  end

  // per-stage valid bits and load enables, stage 5 is the output register
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5 || m_tready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // stage 1: map pixel to normalised coordinates
  orpc_pkg::q_t px, py;
  logic [orpc_pkg::COL_W-1:0] col_in;
  logic [orpc_pkg::ROW_W-1:0] row_in;

  assign col_in = s_tdata[orpc_pkg::COL_W-1:0];
  assign row_in = s_tdata[orpc_pkg::COL_W+orpc_pkg::ROW_W-1:orpc_pkg::COL_W];

  always_ff @(posedge clk) begin
    if (en1) begin
      px <= orpc_pkg::PX_TAB[col_in];
      py <= orpc_pkg::PY_TAB[row_in];
    end
  end

  // stage 2: offset from the centre
  orpc_pkg::q_t dx, dy;
  logic signed [16:0] dx_full, dy_full;

  assign dx_full = 17'(px) - 17'(center_x);
  assign dy_full = 17'(py) - 17'(center_y);

  always_ff @(posedge clk) begin
    if (en2) begin
      dx <= orpc_pkg::sat16(34'(dx_full));
      dy <= orpc_pkg::sat16(34'(dy_full));
    end
  end

  // stage 3: projection products
  logic signed [31:0] m_ux, m_uy, m_vx, m_vy;

  always_ff @(posedge clk) begin
    if (en3) begin
      m_ux <= axis_u_x * dx;
      m_uy <= axis_u_y * dy;
      m_vx <= axis_v_x * dx;
      m_vy <= axis_v_y * dy;
    end
  end

  // stage 4: sum, floor to Q12, saturate and take magnitude
  logic signed [32:0] sum_u, sum_v;
  logic signed [32:0] shr_u, shr_v;
  orpc_pkg::q_t pu, pv;
  logic [14:0] mag_u, mag_v;

  assign sum_u = 33'(m_ux) + 33'(m_uy);
  assign sum_v = 33'(m_vx) + 33'(m_vy);
  assign shr_u = sum_u >>> orpc_pkg::Q_FRAC;
  assign shr_v = sum_v >>> orpc_pkg::Q_FRAC;
  assign pu = orpc_pkg::sat16(34'(shr_u));
  assign pv = orpc_pkg::sat16(34'(shr_v));

  // most negative value saturates to the largest magnitude
  function automatic logic [14:0] abs_sat(input orpc_pkg::q_t v);
    orpc_pkg::q_t n;
    logic [14:0] r;
    n = -v;
    if (v == orpc_pkg::Q_MIN) begin
      r = 15'h7fff;
    end else if (v < 0) begin
      r = n[14:0];
    end else begin
      r = v[14:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en4) begin
      mag_u <= abs_sat(pu);
      mag_v <= abs_sat(pv);
    end
  end

  // stage 5: compare against squared lengths
  logic covered;

  always_ff @(posedge clk) begin
    if (en5) begin
      covered <= (mag_u <= len_u) && (mag_v <= len_v);
    end
  end

  assign m_tvalid = v5;
  assign m_tdata  = {7'b0, covered};

endmodule

/* tb/sv/tb_top.sv */
// testbench for the oriented rectangle pixel coverage block: directed table, then random phases
// each pixel word is checked against a fixed directed verdict or an in-bench predictor of the coverage flag
// depends on rtl/orpc_pkg.sv and rtl/oriented_rect_pixel_coverage_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int REG_COUNT = 6;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  localparam logic signed [1:0] VERDICT_NO      = 2'sd0;
  localparam logic signed [1:0] VERDICT_YES     = 2'sd1;
  localparam logic signed [1:0] VERDICT_PREDICT = -2'sd1;

  localparam int PIPE_LATENCY    = 8;
  localparam int LONG_HOLD       = 80;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int DIRECTED_LEN    = 31;
  localparam longint Q_ONE       = 64'sd1 << orpc_pkg::Q_FRAC;

  typedef enum logic [1:0] {SHAPE_NOMINAL, SHAPE_FULL, SHAPE_EXTREME} shape_kind_t;

  typedef struct packed {
    logic [orpc_pkg::COL_W-1:0] col;
    logic [orpc_pkg::ROW_W-1:0] row;
    logic                       covered;
  } pixel_verdict_t;

  typedef struct packed {
    logic                       is_write;
    logic [2:0]                 index;
    logic [15:0]                value;
    logic [orpc_pkg::COL_W-1:0] col;
    logic [orpc_pkg::ROW_W-1:0] row;
    logic signed [1:0]          want;
  } step_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;  // [6:0] pixel_column, [12:7] pixel_row, rest zero
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;         // [0] covered, rest zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  orpc_pkg::q_t shape_reg [REG_COUNT];
  pixel_verdict_t    verdict_q [$];
  logic signed [1:0] typed_verdict_q [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_arm = 1'b0;
  logic hold_seen = 1'b0;
  int hold_cnt = 0;
  int stuck_cycles = 0;
  step_t directed_steps [DIRECTED_LEN];

  oriented_rect_pixel_coverage_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp_q(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint floor_div(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  function automatic longint mag_q(input longint v);
    if (v == -32768) return 32767;
    return (v < 0) ? -v : v;
  endfunction

  // screen position to Q3.12, centre offset, then projections onto both half axes
  function automatic logic predict_cover(input logic [orpc_pkg::COL_W-1:0] col,
                                         input logic [orpc_pkg::ROW_W-1:0] row);
    longint h, px, py, dx, dy, ux, uy, vx, vy, pu, pv, lu, lv;
    h  = (orpc_pkg::SCREEN_HEIGHT == 0) ? 1 : orpc_pkg::SCREEN_HEIGHT;
    px = clamp_q(floor_div((2 * longint'(col) - orpc_pkg::SCREEN_WIDTH) * 2048, h));
    py = clamp_q(floor_div((2 * longint'(row) - h) * 4096, h));
    dx = clamp_q(px - shape_reg[orpc_pkg::REG_CENTER_X]);
    dy = clamp_q(py - shape_reg[orpc_pkg::REG_CENTER_Y]);
    ux = shape_reg[orpc_pkg::REG_AXIS_U_X];
    uy = shape_reg[orpc_pkg::REG_AXIS_U_Y];
    vx = shape_reg[orpc_pkg::REG_AXIS_V_X];
    vy = shape_reg[orpc_pkg::REG_AXIS_V_Y];
    pu = clamp_q(floor_div(ux * dx + uy * dy, Q_ONE));
    pv = clamp_q(floor_div(vx * dx + vy * dy, Q_ONE));
    lu = clamp_q(floor_div(ux * ux + uy * uy, Q_ONE));
    lv = clamp_q(floor_div(vx * vx + vy * vy, Q_ONE));
    return (mag_q(pu) <= lu) && (mag_q(pv) <= lv);
  endfunction

  function automatic step_t pix(input int col, input int row, input logic signed [1:0] want);
    step_t s;
    s = '0;
    s.col  = col[orpc_pkg::COL_W-1:0];
    s.row  = row[orpc_pkg::ROW_W-1:0];
    s.want = want;
    return s;
  endfunction

  function automatic step_t wr(input logic [2:0] index, input logic [15:0] value);
    step_t s;
    s = '0;
    s.is_write = 1'b1;
    s.index    = index;
    s.value    = value;
    return s;
  endfunction

  function automatic logic [15:0] pick_reg_value(input shape_kind_t kind, input bit centre);
    logic [15:0] v;
    case (kind)
      SHAPE_NOMINAL: begin
        v = centre ? 16'($urandom_range(8192) - 4096) : 16'($urandom_range(6000) - 3000);
      end
      SHAPE_FULL: begin
        v = 16'($urandom);
      end
      default: begin
        case ($urandom_range(6))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'h0000;
          3: v = 16'h0001;
          4: v = 16'hffff;
          5: v = 16'h1000;
          default: v = 16'hf000;
        endcase
      end
    endcase
    return v;
  endfunction

  // scoreboard: predict on pixel acceptance, compare on result acceptance, mirror registers
  always @(posedge clk) begin
    pixel_verdict_t v;
    logic signed [1:0] typed;
    if (rst) begin
      shape_reg[orpc_pkg::REG_CENTER_X] <= 16'sd0;
      shape_reg[orpc_pkg::REG_CENTER_Y] <= 16'sd0;
      shape_reg[orpc_pkg::REG_AXIS_U_X] <= 16'sd2048;
      shape_reg[orpc_pkg::REG_AXIS_U_Y] <= 16'sd0;
      shape_reg[orpc_pkg::REG_AXIS_V_X] <= 16'sd0;
      shape_reg[orpc_pkg::REG_AXIS_V_Y] <= -16'sd2048;
    end else begin
      if (s_tvalid && s_tready) begin
        v.col = s_tdata[orpc_pkg::COL_W-1:0];
        v.row = s_tdata[orpc_pkg::COL_W+orpc_pkg::ROW_W-1:orpc_pkg::COL_W];
        typed = (typed_verdict_q.size() != 0) ? typed_verdict_q.pop_front() : VERDICT_PREDICT;
        v.covered = (typed == VERDICT_PREDICT) ? predict_cover(v.col, v.row) : typed[0];
        verdict_q.push_back(v);
      end
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual covered=%0b",
                   $time, m_tdata[0]);
          mismatches++;
        end else begin
          v = verdict_q.pop_front();
          if (m_tdata[0] !== v.covered) begin
            $display("%0t: covered mismatch at pixel (%0d,%0d): expected %0b, actual %0b",
                     $time, v.col, v.row, v.covered, m_tdata[0]);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready && cfg_index < REG_COUNT) shape_reg[cfg_index] <= cfg_data;
    end
  end

  // result side back-pressure, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_arm != hold_seen) begin
      hold_seen <= hold_arm;
      hold_cnt  <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] index, input logic [15:0] value, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [orpc_pkg::COL_W-1:0] col,
                            input logic [orpc_pkg::ROW_W-1:0] row,
                            input logic signed [1:0] want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    typed_verdict_q.push_back(want);
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, row, col};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // drain every outstanding word so that the block is idle
  task automatic settle_block();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic load_shape(input shape_kind_t kind);
    write_reg(orpc_pkg::REG_CENTER_X, pick_reg_value(kind, 1'b1), 1'b0);
    write_reg(orpc_pkg::REG_CENTER_Y, pick_reg_value(kind, 1'b1), 1'b0);
    write_reg(orpc_pkg::REG_AXIS_U_X, pick_reg_value(kind, 1'b0), 1'b0);
    write_reg(orpc_pkg::REG_AXIS_U_Y, pick_reg_value(kind, 1'b0), 1'b0);
    write_reg(orpc_pkg::REG_AXIS_V_X, pick_reg_value(kind, 1'b0), 1'b0);
    write_reg(orpc_pkg::REG_AXIS_V_Y, pick_reg_value(kind, 1'b0), 1'b0);
    // indexes past the list must leave the shape alone
    write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom), 1'b1);
  endtask

  initial begin
    shape_kind_t kind;
    int mode;
    int rnd_col;
    int rnd_row;
    directed_steps = '{
      // reset shape: half axes of 0.5, so columns 32..96 and rows 16..48 are inside
      pix(0, 0, VERDICT_NO), pix(127, 63, VERDICT_NO), pix(64, 32, VERDICT_YES),
      pix(32, 16, VERDICT_YES), pix(96, 48, VERDICT_YES), pix(31, 32, VERDICT_NO),
      pix(97, 32, VERDICT_NO), pix(64, 15, VERDICT_NO), pix(64, 49, VERDICT_NO),
      pix(127, 0, VERDICT_NO), pix(0, 63, VERDICT_NO),
      // full scale centre and axes, so offsets and projections saturate
      wr(orpc_pkg::REG_CENTER_X, 16'h8000), wr(orpc_pkg::REG_CENTER_Y, 16'h7fff),
      wr(orpc_pkg::REG_AXIS_U_X, 16'h7fff), wr(orpc_pkg::REG_AXIS_U_Y, 16'h7fff),
      wr(orpc_pkg::REG_AXIS_V_X, 16'h8000), wr(orpc_pkg::REG_AXIS_V_Y, 16'h8000),
      wr(REG_SPARE_A, 16'h1234), wr(REG_SPARE_B, 16'hfedc),
      pix(0, 0, VERDICT_PREDICT), pix(127, 63, VERDICT_PREDICT),
      pix(64, 32, VERDICT_PREDICT), pix(127, 0, VERDICT_PREDICT),
      // zero axes: both projections and lengths are zero, every pixel counts as inside
      wr(orpc_pkg::REG_CENTER_X, 16'h0000), wr(orpc_pkg::REG_CENTER_Y, 16'h0000),
      wr(orpc_pkg::REG_AXIS_U_X, 16'h0000), wr(orpc_pkg::REG_AXIS_U_Y, 16'h0000),
      wr(orpc_pkg::REG_AXIS_V_X, 16'h0000), wr(orpc_pkg::REG_AXIS_V_Y, 16'h0000),
      pix(0, 0, VERDICT_YES), pix(127, 63, VERDICT_YES)
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      if (directed_steps[i].is_write) begin
        if (i == 0 || !directed_steps[i-1].is_write) settle_block();
        write_reg(directed_steps[i].index, directed_steps[i].value,
                  (i + 1 == DIRECTED_LEN) || !directed_steps[i+1].is_write);
      end else begin
        send_pixel(directed_steps[i].col, directed_steps[i].row, directed_steps[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle_block();
      if (p == 3 || p == 7) kind = SHAPE_EXTREME;
      else if (p == 2 || p == 5) kind = SHAPE_FULL;
      else kind = SHAPE_NOMINAL;
      load_shape(kind);
      // idling: none, sender only, receiver only, both
      mode = p % 4;
      send_idle_pct  = (mode == 1) ? 56 : (mode == 3) ? 32 : 0;
      recv_stall_pct <= (mode == 2) ? 56 : (mode == 3) ? 32 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (mode == 0 && n == 60) hold_arm <= ~hold_arm;
        rnd_col = $urandom_range(orpc_pkg::COL_CODES - 1);
        rnd_row = $urandom_range(orpc_pkg::ROW_CODES - 1);
        send_pixel(rnd_col[orpc_pkg::COL_W-1:0], rnd_row[orpc_pkg::ROW_W-1:0],
                   VERDICT_PREDICT);
      end
    end
    settle_block();

    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
